[sv/vdf_pkg.sv]
// Shared types, constants and the sine polynomial for the vortex deformation field unit.
// No dependencies; every other file takes names from here by scope.
package vdf_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned TIME_W    = 31;
  localparam int unsigned PHASE_W   = 31;
  localparam int unsigned MAG_W     = 31;
  localparam int unsigned RAD_W     = 66;
  localparam int unsigned REM_W     = 36;
  localparam int unsigned ROOT_W    = 33;
  localparam int unsigned SQRT_CELLS = 33;
  localparam int unsigned N_FAC     = 4;

  localparam logic [MAG_W-1:0]   TRIG_ONE = 31'h4000_0000;
  localparam logic [PHASE_W-1:0] QUARTER  = 31'h2000_0000;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_DIMENSION = 2'd0;
  localparam logic [1:0] REG_KIND      = 2'd1;
  localparam logic [1:0] REG_REV_TIME  = 2'd2;
  localparam logic [1:0] REG_COS_RATE  = 2'd3;

  localparam logic [1:0] DIM_3D   = 2'd3;
  localparam logic [1:0] DIM_RST  = 2'd2;

  // Odd polynomial for sin(pi/2*u), Horner coefficients in Q1.30
  localparam logic [MAG_W-1:0] POLY_COEF [6] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995, 31'd172272, 31'd3864
  };

  // Sign and magnitude in Q1.30; neg is only ever set with a non-zero magnitude
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } trig_t;

  typedef trig_t [N_FAC-1:0] fac_vec_t;

  localparam trig_t TRIG_POS_ONE = '{neg: 1'b0, mag: TRIG_ONE};
  localparam trig_t TRIG_NEG_ONE = '{neg: 1'b1, mag: TRIG_ONE};

endpackage

[sv/vdf_if.sv]
// Channel interfaces of the vortex deformation field unit: points in, velocities out, config.
// Depends on vdf_pkg for the field widths.
interface vdf_pt_if;
  logic                               valid;
  logic                               ready;
  logic signed [vdf_pkg::COORD_W-1:0] x_coord;
  logic signed [vdf_pkg::COORD_W-1:0] y_coord;
  logic signed [vdf_pkg::COORD_W-1:0] z_coord;
  logic        [vdf_pkg::TIME_W-1:0]  sim_time;
  modport source (output valid, x_coord, y_coord, z_coord, sim_time, input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, sim_time, output ready);
endinterface

interface vdf_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [vdf_pkg::COORD_W-1:0] vel_x;
  logic signed [vdf_pkg::COORD_W-1:0] vel_y;
  logic signed [vdf_pkg::COORD_W-1:0] vel_z;
  logic                               saturated;
  modport source (output valid, vel_x, vel_y, vel_z, saturated, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, saturated, output ready);
endinterface

interface vdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/vdf_sine.sv]
// Seven-stage pipelined sine of a phase whose full range is one turn, one Horner step per stage.
// Depends on vdf_pkg for trig_t and the polynomial coefficients.
module vdf_sine (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [vdf_pkg::PHASE_W-1:0]  phase_i,
  output vdf_pkg::trig_t               sin_o
);

  logic [1:0]                 q_q  [6];
  logic [vdf_pkg::MAG_W-1:0]  u_q  [6];
  logic [vdf_pkg::MAG_W-1:0]  u2_q [5];
  logic [vdf_pkg::MAG_W-1:0]  t_q  [1:5];
  logic [vdf_pkg::MAG_W-1:0]  t_in [1:5];
  logic [61:0]                hp   [1:5];
  logic [vdf_pkg::MAG_W-1:0]  u_d;
  logic [61:0]                uu;
  logic [61:0]                ut;
  logic [vdf_pkg::MAG_W-1:0]  s_d;

  // Fold the phase into a quarter wave
  always_comb begin
    u_d = {1'b0, phase_i[28:0], 1'b0};
    if (phase_i[29]) begin
      u_d = vdf_pkg::TRIG_ONE - u_d;
    end
    uu = 62'(u_d) * 62'(u_d);
  end

  // Horner products, one per stage
  always_comb begin
    t_in[1] = vdf_pkg::POLY_COEF[5];
    for (int k = 2; k <= 5; k++) begin
      t_in[k] = t_q[k-1];
    end
    for (int k = 1; k <= 5; k++) begin
      hp[k] = 62'(u2_q[k-1]) * 62'(t_in[k]);
    end
    ut  = 62'(u_q[5]) * 62'(t_q[5]);
    s_d = ut[60:30];
  end

  // Advance the stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q[0]  <= phase_i[30:29];
      u_q[0]  <= u_d;
      u2_q[0] <= uu[60:30];
      for (int k = 1; k <= 5; k++) begin
        q_q[k]  <= q_q[k-1];
        u_q[k]  <= u_q[k-1];
        t_q[k]  <= vdf_pkg::POLY_COEF[5-k] - hp[k][60:30];
      end
      for (int k = 1; k <= 4; k++) begin
        u2_q[k] <= u2_q[k-1];
      end
      sin_o.mag <= s_d;
      sin_o.neg <= q_q[5][1] && (s_d != '0);
    end
  end

endmodule

[sv/vdf_mul_cell.sv]
// Product cell: multiplies the running product by the head factor and hands the rest on.
// Depends on vdf_pkg for trig_t and fac_vec_t.
module vdf_mul_cell (
  input  logic                clk_i,
  input  logic                en_i,
  input  vdf_pkg::trig_t      acc_i,
  input  vdf_pkg::fac_vec_t   fac_i,
  output vdf_pkg::trig_t      acc_o,
  output vdf_pkg::fac_vec_t   fac_o
);

  logic [61:0]               prod;
  logic [vdf_pkg::MAG_W-1:0] p_mag;

  // Truncate the magnitude product, then apply the sign
  always_comb begin
    prod  = 62'(acc_i.mag) * 62'(fac_i[0].mag);
    p_mag = prod[60:30];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_o.mag <= p_mag;
      acc_o.neg <= (acc_i.neg ^ fac_i[0].neg) && (p_mag != '0);
      for (int k = 0; k < vdf_pkg::N_FAC - 1; k++) begin
        fac_o[k] <= fac_i[k+1];
      end
      fac_o[vdf_pkg::N_FAC-1] <= vdf_pkg::TRIG_POS_ONE;
    end
  end

endmodule

[sv/vdf_sqrt_cell.sv]
// Square root cell: settles one root bit from the next two radicand bits.
// Depends on vdf_pkg for the radicand, remainder and root widths.
module vdf_sqrt_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [vdf_pkg::RAD_W-1:0]    rad_i,
  input  logic [vdf_pkg::REM_W-1:0]    rem_i,
  input  logic [vdf_pkg::ROOT_W-1:0]   root_i,
  output logic [vdf_pkg::RAD_W-1:0]    rad_o,
  output logic [vdf_pkg::REM_W-1:0]    rem_o,
  output logic [vdf_pkg::ROOT_W-1:0]   root_o
);

  logic [vdf_pkg::REM_W+1:0] cur;
  logic [vdf_pkg::REM_W+1:0] trial;
  logic                      take;

  // Trial subtract of 4*root+1
  always_comb begin
    cur   = {rem_i, rad_i[vdf_pkg::RAD_W-1 -: 2]};
    trial = (vdf_pkg::REM_W+2)'({root_i, 2'b01});
    take  = cur >= trial;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[vdf_pkg::RAD_W-3:0], 2'b00};
      rem_o  <= take ? vdf_pkg::REM_W'(cur - trial) : vdf_pkg::REM_W'(cur);
      root_o <= {root_i[vdf_pkg::ROOT_W-2:0], take};
    end
  end

endmodule

[sv/vortex_deformation_field_unit.sv]
// Vortex deformation field unit: one point in, one velocity out, every cycle unless the output stalls.
// Structure: 41 pipeline stages plus the output register. Throughput: one point per cycle while the
// output is not stalled, set by the 33-cell square root chain and the seven-stage sine units, all
// fully pipelined.
// Reset clears the valid bits and returns the registers to dimension 2, all others 0.
// Depends on vdf_pkg, vdf_if, vdf_sine, vdf_mul_cell and vdf_sqrt_cell.
module vortex_deformation_field_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  vdf_pt_if.sink        pt_i,
  vdf_res_if.source     res_o,
  vdf_cfg_if.sink       cfg_i
);

  localparam int unsigned N_STG = 41;
  localparam int unsigned N_CDL = 30;
  localparam int unsigned N_VDL = 28;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } vel_t;

  function automatic logic signed [31:0] settle(vdf_pkg::trig_t v, logic flip, logic dbl);
    logic [30:0] m;
    logic        neg;
    m   = dbl ? 31'(v.mag >> 5) : 31'(v.mag >> 6);
    neg = v.neg ^ (flip && (v.mag != '0));
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Configuration registers
  logic [1:0]  dim_q;
  logic        kind_q;
  logic [30:0] rev_time_q;
  logic [30:0] cos_rate_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q      <= vdf_pkg::DIM_RST;
      kind_q     <= 1'b0;
      rev_time_q <= '0;
      cos_rate_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        vdf_pkg::REG_DIMENSION: dim_q      <= cfg_i.data[1:0];
        vdf_pkg::REG_KIND:      kind_q     <= cfg_i.data[0];
        vdf_pkg::REG_REV_TIME:  rev_time_q <= cfg_i.data;
        vdf_pkg::REG_COS_RATE:  cos_rate_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic is3, k2d1, mul3;
  assign is3  = dim_q == vdf_pkg::DIM_3D;
  assign k2d1 = !is3 && kind_q;
  assign mul3 = is3 && kind_q;

  // Pipeline control: stall everything only when the last stage and output are both full and res_o.ready is low
  logic [N_STG:1] vld_q;
  logic           ov_q;
  logic           en;

  assign en          = !vld_q[N_STG] || !ov_q || res_o.ready;
  assign pt_i.ready  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[N_STG-1:1], pt_i.valid};
      end
      if (en && vld_q[N_STG]) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Stage 1: capture the point, time product, reversal flag and offset magnitudes
  logic signed [31:0] x_q, y_q, z_q;
  logic [61:0]        trp_q;
  logic [31:0]        mx_q, my_q;
  logic               rev_dl [1:8];
  logic signed [32:0] dx, dy;

  assign dx = 33'(pt_i.x_coord) - 33'sd8388608;
  assign dy = 33'(pt_i.y_coord) - 33'sd8388608;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q       <= pt_i.x_coord;
      y_q       <= pt_i.y_coord;
      z_q       <= pt_i.z_coord;
      trp_q     <= 62'(pt_i.sim_time) * 62'(cos_rate_q);
      mx_q      <= dx[32] ? 32'(-dx) : dx[31:0];
      my_q      <= dy[32] ? 32'(-dy) : dy[31:0];
      rev_dl[1] <= (rev_time_q != '0) && (pt_i.sim_time >= rev_time_q);
      for (int k = 2; k <= 8; k++) begin
        rev_dl[k] <= rev_dl[k-1];
      end
    end
  end

  // Sine phases, selected by field kind
  logic [30:0]    ph [7];
  vdf_pkg::trig_t sn [7];

  always_comb begin
    ph[0] = trp_q[40:10] + vdf_pkg::QUARTER;
    ph[1] = k2d1 ? {x_q[22:0], 8'b0} : {x_q[24:0], 6'b0};
    ph[2] = k2d1 ? {y_q[22:0], 8'b0} : {y_q[23:0], 7'b0};
    ph[3] = k2d1 ? {x_q[22:0], 8'b0} + vdf_pkg::QUARTER : {x_q[23:0], 7'b0};
    ph[4] = k2d1 ? {y_q[22:0], 8'b0} + vdf_pkg::QUARTER : {y_q[24:0], 6'b0};
    ph[5] = {z_q[24:0], 6'b0};
    ph[6] = {z_q[23:0], 7'b0};
  end

  for (genvar g = 0; g < 7; g++) begin : g_sine
    vdf_sine u_sine (.clk_i(clk_i), .en_i(en), .phase_i(ph[g]), .sin_o(sn[g]));
  end

  // Stage 8: time factor and factor lists for the three product chains
  vdf_pkg::trig_t    c8;
  vdf_pkg::fac_vec_t fx, fy, fz;
  vdf_pkg::trig_t    last6;

  always_comb begin
    if (cos_rate_q != '0) begin
      c8 = sn[0];
    end else begin
      c8 = rev_dl[8] ? vdf_pkg::TRIG_NEG_ONE : vdf_pkg::TRIG_POS_ONE;
    end
    last6 = mul3 ? sn[6] : vdf_pkg::TRIG_POS_ONE;
    if (k2d1) begin
      fx = {vdf_pkg::TRIG_POS_ONE, vdf_pkg::TRIG_POS_ONE, sn[2], sn[1]};
      fy = {vdf_pkg::TRIG_POS_ONE, vdf_pkg::TRIG_POS_ONE, sn[4], sn[3]};
    end else begin
      fx = {last6, sn[2], sn[1], sn[1]};
      fy = {last6, sn[4], sn[4], sn[3]};
    end
    fz = {sn[5], sn[5], sn[2], sn[3]};
  end

  // Product chains, stages 9 to 12
  vdf_pkg::trig_t    ax [5], ay [5], az [5];
  vdf_pkg::fac_vec_t vx_f [5], vy_f [5], vz_f [5];

  assign ax[0] = c8;
  assign ay[0] = c8;
  assign az[0] = c8;
  assign vx_f[0] = fx;
  assign vy_f[0] = fy;
  assign vz_f[0] = fz;

  for (genvar g = 0; g < 4; g++) begin : g_chain
    vdf_mul_cell u_mx (.clk_i(clk_i), .en_i(en), .acc_i(ax[g]), .fac_i(vx_f[g]),
                       .acc_o(ax[g+1]), .fac_o(vx_f[g+1]));
    vdf_mul_cell u_my (.clk_i(clk_i), .en_i(en), .acc_i(ay[g]), .fac_i(vy_f[g]),
                       .acc_o(ay[g+1]), .fac_o(vy_f[g+1]));
    vdf_mul_cell u_mz (.clk_i(clk_i), .en_i(en), .acc_i(az[g]), .fac_i(vz_f[g]),
                       .acc_o(az[g+1]), .fac_o(vz_f[g+1]));
  end

  // Shearing radius: squares, sum, then the square root chain
  logic [63:0] sqx_q, sqy_q;
  logic [vdf_pkg::RAD_W-1:0]  rad_s  [vdf_pkg::SQRT_CELLS+1];
  logic [vdf_pkg::REM_W-1:0]  rem_s  [vdf_pkg::SQRT_CELLS+1];
  logic [vdf_pkg::ROOT_W-1:0] root_s [vdf_pkg::SQRT_CELLS+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar g = 0; g < vdf_pkg::SQRT_CELLS; g++) begin : g_sqrt
    vdf_sqrt_cell u_sq (.clk_i(clk_i), .en_i(en),
                        .rad_i(rad_s[g]), .rem_i(rem_s[g]), .root_i(root_s[g]),
                        .rad_o(rad_s[g+1]), .rem_o(rem_s[g+1]), .root_o(root_s[g+1]));
  end

  vdf_pkg::trig_t c_dl [N_CDL];
  vel_t           vel_dl [N_VDL];
  logic [33:0]    w_q;
  logic [67:0]    w2_q;
  logic [52:0]    phi_q, plo_q;
  logic [45:0]    pz_q;
  logic           cn39_q, cn40_q;
  logic [33:0]    r2;
  logic [75:0]    psum;
  logic [45:0]    cap;
  logic [45:0]    pz_m;
  logic           zclip;

  always_comb begin
    r2   = {root_s[vdf_pkg::SQRT_CELLS], 1'b0};
    psum = {1'b0, phi_q, 22'b0} + 76'(plo_q);
    cap  = cn40_q ? 46'h8000_0000 : 46'h7FFF_FFFF;
    zclip = pz_q > cap;
    pz_m = zclip ? cap : pz_q;
  end

  // Advance the data path
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q    <= 64'(mx_q) * 64'(mx_q);
      sqy_q    <= 64'(my_q) * 64'(my_q);
      rad_s[0] <= 66'(sqx_q) + 66'(sqy_q);
      w_q      <= (r2 >= 34'h100_0000) ? r2 - 34'h100_0000 : 34'h100_0000 - r2;
      w2_q     <= 68'(w_q) * 68'(w_q);
      phi_q    <= 53'(w2_q[67:46]) * 53'(c_dl[N_CDL-1].mag);
      plo_q    <= 53'(w2_q[45:24]) * 53'(c_dl[N_CDL-1].mag);
      cn39_q   <= c_dl[N_CDL-1].neg;
      pz_q     <= psum[75:30];
      cn40_q   <= cn39_q;
      c_dl[0]  <= c8;
      for (int k = 1; k < N_CDL; k++) begin
        c_dl[k] <= c_dl[k-1];
      end
      vel_dl[0].vx <= settle(ax[4], !is3 && !kind_q, mul3);
      vel_dl[0].vy <= settle(ay[4], is3, 1'b0);
      vel_dl[0].vz <= settle(az[4], 1'b1, 1'b0);
      for (int k = 1; k < N_VDL; k++) begin
        vel_dl[k] <= vel_dl[k-1];
      end
    end
  end

  // Stage 41 and the output register
  logic signed [31:0] fx_q, fy_q, fz_q;
  logic               fs_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q <= vel_dl[N_VDL-1].vx;
      fy_q <= vel_dl[N_VDL-1].vy;
      if (!is3) begin
        fz_q <= '0;
        fs_q <= 1'b0;
      end else if (kind_q) begin
        fz_q <= vel_dl[N_VDL-1].vz;
        fs_q <= 1'b0;
      end else begin
        fz_q <= cn40_q ? -$signed(pz_m[31:0]) : $signed(pz_m[31:0]);
        fs_q <= zclip;
      end
      if (vld_q[N_STG]) begin
        res_o.vel_x     <= fx_q;
        res_o.vel_y     <= fy_q;
        res_o.vel_z     <= fz_q;
        res_o.saturated <= fs_q;
      end
    end
  end

  assign res_o.valid = ov_q;

endmodule
